[hw/rtl/hsteq_pkg.sv]
// Shared types and constants for the histogram equalizer.
`timescale 1ns / 1ps
`default_nettype none

package hsteq_pkg;

   localparam int unsigned LEVELS      = 256;
   localparam int unsigned ADDR_W      = 8;
   localparam int unsigned COUNT_W     = 25;
   localparam int unsigned CUM_W       = 33;   // 256 bins at the cap
   localparam int unsigned DIVIDEND_W  = 43;   // cum*510 + total
   localparam int unsigned DIVISOR_W   = 26;   // 2*total
   localparam int unsigned QUOT_W      = 8;

   // min(MAX_PIXELS, 2^25-1)
   localparam logic [COUNT_W-1:0] COUNT_CAP = 25'd16777216;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_COUNT = 2'd1,
      CMD_BUILD = 2'd2,
      CMD_MAP   = 2'd3
   } cmd_type;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

   typedef struct packed {
      logic               clear;
      logic               rd_en;
      logic [ADDR_W-1:0]  rd_addr;
      logic               wr_en;
      logic [ADDR_W-1:0]  wr_addr;
      logic [COUNT_W-1:0] wr_data;
      logic               total_inc;
   } hist_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

[hw/rtl/hsteq_div.sv]
// Iterative restoring divider with quotient clamped to 255, one compare-subtract per cycle.
`timescale 1ns / 1ps
`default_nettype none

module hsteq_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [hsteq_pkg::DIVIDEND_W-1:0]  dividend,
   input  wire logic [hsteq_pkg::DIVISOR_W-1:0]   divisor,
   output hsteq_pkg::div_rsp_type                 rsp
);
   import hsteq_pkg::*;

   localparam int unsigned DSH_W = DIVISOR_W + QUOT_W;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [3:0]            step_ff, step_in;
   logic [DIVIDEND_W-1:0] rem_ff, rem_in;
   logic [DSH_W-1:0]      dsh_ff, dsh_in;
   logic [QUOT_W-1:0]     quot_ff, quot_in;
   logic [DIVIDEND_W:0]   diff;
   logic                  ge;

   always_comb begin
      diff = {1'b0, rem_ff} - {{(DIVIDEND_W + 1 - DSH_W){1'b0}}, dsh_ff};
      ge   = ~diff[DIVIDEND_W];

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;

      if (start) begin
         busy_in = 1'b1;
         step_in = 4'(QUOT_W);
         rem_in  = dividend;
         dsh_in  = {divisor, {QUOT_W{1'b0}}};
         quot_in = '0;
      end else if (busy_ff) begin
         dsh_in = dsh_ff >> 1;
         if (step_ff == 4'(QUOT_W)) begin
            // quotient would need a ninth bit: clamp
            if (ge) begin
               quot_in = '1;
               busy_in = 1'b0;
               done_in = 1'b1;
            end
            step_in = step_ff - 4'd1;
         end else begin
            if (ge) begin
               rem_in = diff[DIVIDEND_W-1:0];
            end
            quot_in = {quot_ff[QUOT_W-2:0], ge};
            if (step_ff == 4'd0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               step_in = step_ff - 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quot_ff;

endmodule

`default_nettype wire

[hw/rtl/hsteq_hist.sv]
// Histogram bin memory with per-bin valid bits and the saturating pixel total.
`timescale 1ns / 1ps
`default_nettype none

module hsteq_hist (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire hsteq_pkg::hist_req_type        req,
   output logic [hsteq_pkg::COUNT_W-1:0]       rd_data,
   output logic [hsteq_pkg::COUNT_W-1:0]       total
);
   import hsteq_pkg::*;

   logic [COUNT_W-1:0] bin_mem [LEVELS];
   logic [LEVELS-1:0]  valid_ff, valid_in;
   logic [COUNT_W-1:0] total_ff, total_in;
   logic [COUNT_W-1:0] rd_q_ff;
   logic               rd_vld_ff;

   always_comb begin
      valid_in = valid_ff;
      total_in = total_ff;
      if (req.clear) begin
         valid_in = '0;
         total_in = '0;
      end else begin
         if (req.wr_en) begin
            valid_in[req.wr_addr] = 1'b1;
         end
         if (req.total_inc && (total_ff < COUNT_CAP)) begin
            total_in = total_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         total_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         bin_mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_q_ff   <= bin_mem[req.rd_addr];
         rd_vld_ff <= valid_ff[req.rd_addr];
      end
   end

   // a bin not written since the last clear reads as zero
   assign rd_data = rd_vld_ff ? rd_q_ff : '0;
   assign total   = total_ff;

endmodule

`default_nettype wire

[hw/rtl/histogram_equalizer.sv]
// Histogram equalizer top level: command sequencer, map table and result register.
//
// Usage: commands enter on the req_ channel (req_command, req_pixel_value) and
// are taken when req_valid is high and req_stall is low. req_stall is high
// while a command is being worked; one command is handled at a time.
// clear acts on acceptance and count increments the addressed bin; neither returns a
// transaction. map reads the table and posts its result through S_MAP and S_RESP.
// build walks the 256 bins in order; each bin goes through bin read,
// accumulate, divider start, up to 9 compare-subtract steps in the single
// divider and write; after the last bin it posts one transaction with status. A build on
// an empty histogram goes straight to S_RESP and posts status 1.
// Results sit in an output register on the rsp_ channel; while rsp_stall
// is high the result holds, and a new command may still be accepted, but a
// command with a result waits for the output register to free.
// Reset clears the histogram, the total and the table (all read as zero) at
// once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module histogram_equalizer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_command,
   input  wire logic [7:0]  req_pixel_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_mapped_value,
   output logic             rsp_status
);
   import hsteq_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_CNT_WR  = 8'b0000_0010,
      S_MAP     = 8'b0000_0100,
      S_BLD_RD  = 8'b0000_1000,
      S_BLD_ACC = 8'b0001_0000,
      S_BLD_GO  = 8'b0010_0000,
      S_BLD_DIV = 8'b0100_0000,
      S_RESP    = 8'b1000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  pix_ff, pix_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [CUM_W-1:0]   cum_ff, cum_in;
   logic               map_valid_ff, map_valid_in;
   logic [7:0]         res_value_ff, res_value_in;
   logic               res_status_ff, res_status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_value_ff, rsp_value_in;
   logic               rsp_status_ff, rsp_status_in;

   logic [7:0]         map_mem [LEVELS];
   logic [7:0]         map_q_ff;
   logic               map_rd;
   logic               map_wr;

   hist_req_type            hreq;
   logic [COUNT_W-1:0]      bin_data;
   logic [COUNT_W-1:0]      total;
   logic                    div_start;
   logic [DIVIDEND_W-1:0]   dividend;
   logic [DIVISOR_W-1:0]    divisor;
   div_rsp_type             drsp;
   logic                    accept;
   logic                    out_free;

   hsteq_hist u_hist (
      .clock   (clock),
      .reset   (reset),
      .req     (hreq),
      .rd_data (bin_data),
      .total   (total)
   );

   hsteq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .rsp      (drsp)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // round half up of cum*255/total as floor((cum*510 + total) / (2*total))
   assign dividend = ({{(DIVIDEND_W - CUM_W){1'b0}}, cum_ff} << 9)
                   - ({{(DIVIDEND_W - CUM_W){1'b0}}, cum_ff} << 1)
                   + {{(DIVIDEND_W - COUNT_W){1'b0}}, total};
   assign divisor  = {total, 1'b0};

   always_comb begin
      state_in      = state_ff;
      pix_in        = pix_ff;
      idx_in        = idx_ff;
      cum_in        = cum_ff;
      map_valid_in  = map_valid_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;

      hreq          = '0;
      hreq.rd_addr  = req_pixel_value;
      hreq.wr_addr  = pix_ff;
      hreq.wr_data  = (bin_data < COUNT_CAP) ? bin_data + COUNT_W'(1) : COUNT_CAP;
      map_rd        = 1'b0;
      map_wr        = 1'b0;
      div_start     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pix_in = req_pixel_value;
               case (req_command)
                  CMD_CLEAR: begin
                     hreq.clear = 1'b1;
                  end
                  CMD_COUNT: begin
                     hreq.rd_en = 1'b1;
                     state_in   = S_CNT_WR;
                  end
                  CMD_BUILD: begin
                     res_value_in = '0;
                     if (total == '0) begin
                        map_valid_in  = 1'b0;
                        res_status_in = STATUS_EMPTY;
                        state_in      = S_RESP;
                     end else begin
                        idx_in   = '0;
                        cum_in   = '0;
                        state_in = S_BLD_RD;
                     end
                  end
                  default: begin
                     map_rd   = 1'b1;
                     state_in = S_MAP;
                  end
               endcase
            end
         end
         S_CNT_WR: begin
            hreq.wr_en     = 1'b1;
            hreq.total_inc = 1'b1;
            state_in       = S_IDLE;
         end
         S_MAP: begin
            res_value_in  = map_valid_ff ? map_q_ff : '0;
            res_status_in = STATUS_OK;
            state_in      = S_RESP;
         end
         S_BLD_RD: begin
            hreq.rd_en   = 1'b1;
            hreq.rd_addr = idx_ff;
            state_in     = S_BLD_ACC;
         end
         S_BLD_ACC: begin
            cum_in   = cum_ff + {{(CUM_W - COUNT_W){1'b0}}, bin_data};
            state_in = S_BLD_GO;
         end
         S_BLD_GO: begin
            div_start = 1'b1;
            state_in  = S_BLD_DIV;
         end
         S_BLD_DIV: begin
            if (drsp.done) begin
               map_wr = 1'b1;
               if (idx_ff == ADDR_W'(LEVELS - 1)) begin
                  map_valid_in  = 1'b1;
                  res_status_in = STATUS_OK;
                  state_in      = S_RESP;
               end else begin
                  idx_in   = idx_ff + ADDR_W'(1);
                  state_in = S_BLD_RD;
               end
            end
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         map_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         map_valid_ff <= map_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pix_ff        <= pix_in;
      idx_ff        <= idx_in;
      cum_ff        <= cum_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (map_wr) begin
         map_mem[idx_ff] <= drsp.quotient;
      end
      if (map_rd) begin
         map_q_ff <= map_mem[req_pixel_value];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mapped_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

`default_nettype wire

[tb/histogram_equalizer_checker.sv]
// Scoreboard for the histogram equalizer: tracks histogram and table, checks every result.
`timescale 1ns / 1ps

module histogram_equalizer_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [1:0]  req_command,
   input  wire logic [7:0]  req_pixel_value,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [7:0]  rsp_mapped_value,
   input  wire logic        rsp_status,
   output int unsigned      mismatches,
   output int unsigned      outstanding
);
   import hsteq_pkg::*;

   typedef struct packed {
      logic [7:0] mapped_value;
      logic       status;
   } eq_result_type;

   logic [COUNT_W-1:0] bin_count [LEVELS];
   logic [COUNT_W-1:0] pixel_total;
   logic [7:0]         eq_lut [LEVELS];
   eq_result_type      expected_results [$];
   eq_result_type      oldest;

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // cumulative walk: entry = round-half-up(cum * 255 / total), clamped
   task automatic rebuild_lut(output logic empty_flag);
      logic [63:0] cum;
      logic [63:0] total;
      logic [63:0] quot;
      total = 64'(pixel_total);
      cum   = '0;
      if (total == 0) begin
         for (int i = 0; i < LEVELS; i++) eq_lut[i] = '0;
         empty_flag = STATUS_EMPTY;
      end else begin
         for (int i = 0; i < LEVELS; i++) begin
            cum  = cum + 64'(bin_count[i]);
            quot = (cum * 64'd510 + total) / (total * 64'd2);
            if (quot > 64'd255) quot = 64'd255;
            eq_lut[i] = quot[7:0];
         end
         empty_flag = STATUS_OK;
      end
   endtask

   task automatic apply_transaction(input cmd_type cmd, input logic [7:0] pix);
      eq_result_type res;
      logic          empty_flag;
      case (cmd)
         CMD_CLEAR: begin
            for (int i = 0; i < LEVELS; i++) bin_count[i] = '0;
            pixel_total = '0;
         end
         CMD_COUNT: begin
            if (bin_count[pix] < COUNT_CAP) bin_count[pix] = bin_count[pix] + 1'b1;
            if (pixel_total < COUNT_CAP) pixel_total = pixel_total + 1'b1;
         end
         CMD_BUILD: begin
            rebuild_lut(empty_flag);
            res.mapped_value = '0;
            res.status       = empty_flag;
            expected_results.push_back(res);
         end
         default: begin
            res.mapped_value = eq_lut[pix];
            res.status       = STATUS_OK;
            expected_results.push_back(res);
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEVELS; i++) begin
            bin_count[i] = '0;
            eq_lut[i]    = '0;
         end
         pixel_total = '0;
         expected_results.delete();
      end else begin
         // results first: none can stem from a request taken at this same edge
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result with nothing expected: mapped=%0d status=%0d",
                                         rsp_mapped_value, rsp_status));
            end else begin
               oldest = expected_results.pop_front();
               if (rsp_mapped_value !== oldest.mapped_value) begin
                  report_mismatch($sformatf("mapped_value got %0d expected %0d",
                                            rsp_mapped_value, oldest.mapped_value));
               end
               if (rsp_status !== oldest.status) begin
                  report_mismatch($sformatf("status got %0d expected %0d",
                                            rsp_status, oldest.status));
               end
            end
         end
         if (req_valid && !req_stall) begin
            apply_transaction(cmd_type'(req_command), req_pixel_value);
         end
      end
      outstanding <= expected_results.size();
   end

endmodule

[tb/histogram_equalizer_test.sv]
// Testbench top for the histogram equalizer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module histogram_equalizer_test;
   import hsteq_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 1150;
   localparam int unsigned DRAIN_CYCLES = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = CMD_CLEAR;
   logic [7:0]  req_pixel_value = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_mapped_value;
   logic        rsp_status;

   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned send_idle_pct = 22;
   int unsigned recv_idle_pct = 65;
   int unsigned items_sent = 0;

   always #1 clock = ~clock;

   histogram_equalizer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_pixel_value  (req_pixel_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mapped_value (rsp_mapped_value),
      .rsp_status       (rsp_status)
   );

   histogram_equalizer_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_pixel_value  (req_pixel_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mapped_value (rsp_mapped_value),
      .rsp_status       (rsp_status),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // valid stays high across back-to-back transactions; it only drops on a gap
   task automatic send_command(input cmd_type cmd, input logic [7:0] pix);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_pixel_value <= pix;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic map_some(input int unsigned base, input int unsigned spread);
      int unsigned n_map;
      n_map = $urandom_range(1, 12);
      repeat (n_map) begin
         if ($urandom_range(2) == 0) send_command(CMD_MAP, 8'(base + $urandom_range(spread)));
         else send_command(CMD_MAP, 8'($urandom));
      end
   endtask

   // mostly clear/count/build/map runs; some noise, empty builds and missing builds
   task automatic random_burst();
      int unsigned kind;
      int unsigned n_count;
      int unsigned base;
      int unsigned spread;
      kind   = $urandom_range(99);
      base   = $urandom_range(255);
      spread = $urandom_range(255);
      if (kind < 12) begin
         send_command(cmd_type'($urandom_range(3)), 8'($urandom));
      end else if (kind < 17) begin
         send_command(CMD_CLEAR, 8'($urandom));
         send_command(CMD_BUILD, 8'($urandom));
         map_some(base, spread);
      end else begin
         if ($urandom_range(1) == 1) send_command(CMD_CLEAR, 8'($urandom));
         n_count = $urandom_range(1, 40);
         repeat (n_count) send_command(CMD_COUNT, 8'(base + $urandom_range(spread)));
         if (kind >= 25) send_command(CMD_BUILD, 8'($urandom));
         map_some(base, spread);
      end
   endtask

   initial begin
      int unsigned directed_items;
      int unsigned phase;
      int unsigned next_phase;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // table reads zero before any build
      send_command(CMD_MAP, 8'd0);
      send_command(CMD_MAP, 8'd255);
      // empty histogram
      send_command(CMD_BUILD, 8'd0);
      send_command(CMD_COUNT, 8'd0);
      send_command(CMD_COUNT, 8'd255);
      send_command(CMD_COUNT, 8'd255);
      send_command(CMD_COUNT, 8'd128);
      send_command(CMD_BUILD, 8'd0);
      send_command(CMD_MAP, 8'd0);
      send_command(CMD_MAP, 8'd127);
      send_command(CMD_MAP, 8'd128);
      send_command(CMD_MAP, 8'd254);
      send_command(CMD_MAP, 8'd255);
      // clear then build: table goes back to all zero
      send_command(CMD_CLEAR, 8'd255);
      send_command(CMD_BUILD, 8'd255);
      send_command(CMD_MAP, 8'd255);
      // single pixel: step from 0 to 255 at its bin
      send_command(CMD_COUNT, 8'd7);
      send_command(CMD_BUILD, 8'd170);
      send_command(CMD_MAP, 8'd6);
      send_command(CMD_MAP, 8'd7);
      send_command(CMD_MAP, 8'd255);
      send_command(CMD_COUNT, 8'd85);
      directed_items = items_sent;

      phase = 0;
      while (items_sent - directed_items < RANDOM_ITEMS) begin
         next_phase = (items_sent - directed_items) * 3 / RANDOM_ITEMS;
         if (next_phase != phase) begin
            // hold off the sender until everything in flight has come back
            wait_drained();
            phase = next_phase;
            if (phase == 1) begin
               send_idle_pct = 65;
               recv_idle_pct = 22;
            end else begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         end
         random_burst();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
